// ----- sv/gradient_magnitude_direction_assert.svh -----
// assertion macros for the gradient magnitude and direction block
`ifndef GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`define GRADIENT_MAGNITUDE_DIRECTION_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GMD_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gmd same-cycle check failed");
// next-cycle implication
`define GMD_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gmd next-cycle check failed");
`else
`define GMD_ASSERT_IMP(name, clk, rst, pre, post)
`define GMD_ASSERT_NXT(name, clk, rst, pre, post)
`endif
`endif

// ----- sv/gmd_pkg.sv -----
// shared constants, types and angle table functions for the gradient block
package gmd_pkg;

  localparam int GRAD_WIDTH_DEF      = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 12;
  localparam int THR_W               = 12;
  localparam int MAG_W               = 12;
  localparam int ANGLE_W             = 15;
  localparam int ANG_SCALE           = 60;
  localparam int CORDIC_STEPS        = 60;
  localparam int PRESHIFT            = 35;

  typedef logic [63:0] word64_t;

  // per-pixel side information that rides along the pipeline
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ax_zero;
    logic ay_zero;
    logic pass;
  } flags_t;

  // shift-subtract quotient, used only while building constants
  function automatic word64_t udiv(input word64_t num, input word64_t den);
    word64_t quo;
    word64_t rm;
    quo = '0;
    rm  = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], num[i]};
      if (rm >= den) begin
        rm     = rm - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) scaled by 2^60, alternating series with truncated terms
  function automatic word64_t atan_recip(input word64_t n);
    word64_t p;
    word64_t sum;
    word64_t term;
    p   = udiv(word64_t'(1) << ANG_SCALE, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = udiv(p, word64_t'(2 * k + 1));
        if ((k & 1) == 0) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        p = udiv(p, n);
        p = udiv(p, n);
      end
    end
    return sum;
  endfunction

  localparam word64_t QUARTER_PI = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
  localparam word64_t HALF_PI    = QUARTER_PI << 1;
  localparam word64_t PI_FIX     = QUARTER_PI << 2;

  // rotation angle of cordic step i
  function automatic word64_t atan_entry(input int i);
    if (i == 0) begin
      return QUARTER_PI;
    end
    return atan_recip(word64_t'(1) << i);
  endfunction

endpackage

// ----- sv/gmd_if.sv -----
// stream and configuration interfaces of the gradient block
interface gmd_pixel_if import gmd_pkg::*; #(parameter int GW = GRAD_WIDTH_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [GW-1:0] grad_x;
  logic signed [GW-1:0] grad_y;
  modport source (output valid, output grad_x, output grad_y, input ready);
  modport sink (input valid, input grad_x, input grad_y, output ready);
endinterface

interface gmd_result_if import gmd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MAG_W-1:0]          magnitude;
  logic signed [ANGLE_W-1:0] angle;
  logic                      above_threshold;
  modport source (output valid, output magnitude, output angle, output above_threshold,
                  input ready);
  modport sink (input valid, input magnitude, input angle, input above_threshold,
                output ready);
endinterface

interface gmd_cfg_if import gmd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/gradient_magnitude_direction.sv -----
// gradient magnitude and atan2 direction, top level with threshold register
// throughput one pixel per cycle while the skid entry is free, through the 60-stage cordic and one-bit-per-stage sqrt
// a two-entry output buffer keeps the input ready while one result waits
// synchronous reset clears all valid bits and sets the threshold to zero
`include "gradient_magnitude_direction_assert.svh"
module gradient_magnitude_direction import gmd_pkg::*; #(
  parameter int GRAD_WIDTH      = GRAD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  gmd_pixel_if.sink    pixel,
  gmd_result_if.source result,
  gmd_cfg_if.sink      cfg
);

  localparam int GW = GRAD_WIDTH;

  logic [2*THR_W-1:0] thr_sq;
  logic               en;

  logic               f_valid;
  logic [GW-1:0]      f_ax;
  logic [GW-1:0]      f_ay;
  logic [2*GW-1:0]    f_sum;
  flags_t             f_flags;

  logic               s_valid;
  logic [GW-1:0]      s_ax;
  logic [GW-1:0]      s_ay;
  flags_t             s_flags;
  logic [MAG_W-1:0]   s_mag;

  logic               c_valid;
  logic signed [63:0] c_z;
  flags_t             c_flags;
  logic [MAG_W-1:0]   c_mag;

  logic                      b_valid;
  logic [MAG_W-1:0]          b_mag;
  logic signed [ANGLE_W-1:0] b_ang;
  logic                      b_pass;

  logic                      out_valid;
  logic [MAG_W-1:0]          out_mag;
  logic signed [ANGLE_W-1:0] out_ang;
  logic                      out_pass;
  logic                      skid_valid;
  logic [MAG_W-1:0]          skid_mag;
  logic signed [ANGLE_W-1:0] skid_ang;
  logic                      skid_pass;
  logic                      take;

  // threshold register, held as its square
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq <= '0;
    end else if (cfg.valid && cfg.ready) begin
      thr_sq <= (2 * THR_W)'(cfg.data) * (2 * THR_W)'(cfg.data);
    end
  end

  // whole pipe moves while the skid entry is free
  assign en          = !skid_valid;
  assign pixel.ready = en;

  gmd_front #(.GW(GW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel.valid),
    .grad_x    (pixel.grad_x),
    .grad_y    (pixel.grad_y),
    .thr_sq    (thr_sq),
    .out_valid (f_valid),
    .ax        (f_ax),
    .ay        (f_ay),
    .sum_sq    (f_sum),
    .flags     (f_flags)
  );

  gmd_sqrt #(.GW(GW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_ax     (f_ax),
    .in_ay     (f_ay),
    .sum_sq    (f_sum),
    .in_flags  (f_flags),
    .out_valid (s_valid),
    .out_ax    (s_ax),
    .out_ay    (s_ay),
    .out_flags (s_flags),
    .magnitude (s_mag)
  );

  gmd_cordic #(.GW(GW)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .ax        (s_ax),
    .ay        (s_ay),
    .in_flags  (s_flags),
    .in_mag    (s_mag),
    .out_valid (c_valid),
    .z         (c_z),
    .out_flags (c_flags),
    .out_mag   (c_mag)
  );

  gmd_back #(.AFB(ANGLE_FRAC_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (c_valid),
    .z               (c_z),
    .in_flags        (c_flags),
    .in_mag          (c_mag),
    .out_valid       (b_valid),
    .magnitude       (b_mag),
    .angle           (b_ang),
    .above_threshold (b_pass)
  );

  // output register with skid entry
  assign take = en && b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_mag  <= skid_valid ? skid_mag : b_mag;
      out_ang  <= skid_valid ? skid_ang : b_ang;
      out_pass <= skid_valid ? skid_pass : b_pass;
    end else if (take) begin
      skid_mag  <= b_mag;
      skid_ang  <= b_ang;
      skid_pass <= b_pass;
    end
  end

  assign result.valid           = out_valid;
  assign result.magnitude       = out_mag;
  assign result.angle           = out_ang;
  assign result.above_threshold = out_pass;

  // checks
  `GMD_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `GMD_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && result.ready, !skid_valid)
  `GMD_ASSERT_IMP(a_angle_needs_pass, clk, rst, out_valid && (out_ang != '0), out_pass)
  `GMD_ASSERT_IMP(a_zero_mag_no_angle, clk, rst, out_valid && (out_mag == '0), out_ang == '0)

endmodule

// ----- sv/gmd_front.sv -----
// front stages: input register, absolute values and squares, sum and threshold test
module gmd_front import gmd_pkg::*; #(
  parameter int GW = GRAD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [GW-1:0] grad_x,
  input  logic signed [GW-1:0] grad_y,
  input  logic [2*THR_W-1:0]   thr_sq,
  output logic                 out_valid,
  output logic [GW-1:0]        ax,
  output logic [GW-1:0]        ay,
  output logic [2*GW-1:0]      sum_sq,
  output flags_t               flags
);

  localparam int SW = 2 * GW;
  localparam int CW = (SW > 2 * THR_W) ? SW : 2 * THR_W;

  logic          v1;
  logic [GW-1:0] gx1;
  logic [GW-1:0] gy1;
  logic          v2;
  logic [GW-1:0] ax2;
  logic [GW-1:0] ay2;
  logic [SW-1:0] sqx2;
  logic [SW-1:0] sqy2;
  flags_t        fl2;

  logic [GW-1:0] ax_c;
  logic [GW-1:0] ay_c;
  logic [SW-1:0] s_c;
  flags_t        fl_c;

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // magnitudes of the two components
  assign ax_c = gx1[GW-1] ? GW'(~gx1 + 1'b1) : gx1;
  assign ay_c = gy1[GW-1] ? GW'(~gy1 + 1'b1) : gy1;

  // squared length
  assign s_c = sqx2 + sqy2;

  // threshold test joins the carried flags
  always_comb begin
    fl_c      = fl2;
    fl_c.pass = (CW'(s_c) >= CW'(thr_sq));
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      gx1           <= grad_x;
      gy1           <= grad_y;
      ax2           <= ax_c;
      ay2           <= ay_c;
      sqx2          <= SW'(ax_c) * SW'(ax_c);
      sqy2          <= SW'(ay_c) * SW'(ay_c);
      fl2.neg_x     <= gx1[GW-1];
      fl2.neg_y     <= gy1[GW-1];
      fl2.ax_zero   <= (gx1 == '0);
      fl2.ay_zero   <= (gy1 == '0);
      fl2.pass      <= 1'b0;
      ax            <= ax2;
      ay            <= ay2;
      sum_sq        <= s_c;
      flags         <= fl_c;
    end
  end

endmodule

// ----- sv/gmd_sqrt.sv -----
// pipelined integer square root, one root bit per stage, then round to nearest
module gmd_sqrt import gmd_pkg::*; #(
  parameter int GW = GRAD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [GW-1:0]     in_ax,
  input  logic [GW-1:0]     in_ay,
  input  logic [2*GW-1:0]   sum_sq,
  input  flags_t            in_flags,
  output logic              out_valid,
  output logic [GW-1:0]     out_ax,
  output logic [GW-1:0]     out_ay,
  output flags_t            out_flags,
  output logic [MAG_W-1:0]  magnitude
);

  localparam int SW = 2 * GW;

  logic          v_q   [GW];
  logic [GW-1:0] r_q   [GW];
  logic [SW-1:0] rem_q [GW];
  logic [GW-1:0] ax_q  [GW];
  logic [GW-1:0] ay_q  [GW];
  flags_t        fl_q  [GW];

  logic          up;
  logic [GW:0]   r_round;

  for (genvar j = 0; j < GW; j++) begin : g_bit
    localparam int K = GW - 1 - j;
    logic          v_i;
    logic [GW-1:0] r_i;
    logic [SW-1:0] rem_i;
    logic [GW-1:0] ax_i;
    logic [GW-1:0] ay_i;
    flags_t        fl_i;
    logic [SW:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign v_i   = in_valid;
      assign r_i   = '0;
      assign rem_i = sum_sq;
      assign ax_i  = in_ax;
      assign ay_i  = in_ay;
      assign fl_i  = in_flags;
    end else begin : g_rest
      assign v_i   = v_q[j-1];
      assign r_i   = r_q[j-1];
      assign rem_i = rem_q[j-1];
      assign ax_i  = ax_q[j-1];
      assign ay_i  = ay_q[j-1];
      assign fl_i  = fl_q[j-1];
    end

    // (r + 2^k)^2 - r^2 against what is left of the square
    assign trial = ((SW + 1)'(r_i) << (K + 1)) + ((SW + 1)'(1) << (2 * K));
    assign take  = (trial <= {1'b0, rem_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[j]   <= take ? (r_i | (GW'(1) << K)) : r_i;
        rem_q[j] <= take ? (rem_i - trial[SW-1:0]) : rem_i;
        ax_q[j]  <= ax_i;
        ay_q[j]  <= ay_i;
        fl_q[j]  <= fl_i;
      end
    end
  end

  // round up when the square lies past r^2 + r
  assign up      = (rem_q[GW-1] > SW'(r_q[GW-1]));
  assign r_round = (GW + 1)'(r_q[GW-1]) + (GW + 1)'(up);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[GW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ax    <= ax_q[GW-1];
      out_ay    <= ay_q[GW-1];
      out_flags <= fl_q[GW-1];
      magnitude <= MAG_W'(r_round);
    end
  end

endmodule

// ----- sv/gmd_cordic.sv -----
// first-quadrant vectoring cordic, one rotation per stage
module gmd_cordic import gmd_pkg::*; #(
  parameter int GW = GRAD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [GW-1:0]      ax,
  input  logic [GW-1:0]      ay,
  input  flags_t             in_flags,
  input  logic [MAG_W-1:0]   in_mag,
  output logic               out_valid,
  output logic signed [63:0] z,
  output flags_t             out_flags,
  output logic [MAG_W-1:0]   out_mag
);

  localparam int XW = GW + PRESHIFT + 2;

  logic                 v_q   [CORDIC_STEPS];
  logic signed [XW-1:0] x_q   [CORDIC_STEPS];
  logic signed [XW-1:0] y_q   [CORDIC_STEPS];
  logic signed [63:0]   z_q   [CORDIC_STEPS];
  flags_t               fl_q  [CORDIC_STEPS];
  logic [MAG_W-1:0]     mag_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [63:0] ANG = signed'(atan_entry(i));
    logic                 v_i;
    logic signed [XW-1:0] x_i;
    logic signed [XW-1:0] y_i;
    logic signed [63:0]   z_i;
    flags_t               fl_i;
    logic [MAG_W-1:0]     mag_i;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 pos;

    if (i == 0) begin : g_first
      assign v_i   = in_valid;
      assign x_i   = signed'({2'b00, ax, {PRESHIFT{1'b0}}});
      assign y_i   = signed'({2'b00, ay, {PRESHIFT{1'b0}}});
      assign z_i   = '0;
      assign fl_i  = in_flags;
      assign mag_i = in_mag;
    end else begin : g_rest
      assign v_i   = v_q[i-1];
      assign x_i   = x_q[i-1];
      assign y_i   = y_q[i-1];
      assign z_i   = z_q[i-1];
      assign fl_i  = fl_q[i-1];
      assign mag_i = mag_q[i-1];
    end

    // floor shifts and rotation direction
    assign dx  = y_i >>> i;
    assign dy  = x_i >>> i;
    assign pos = !y_i[XW-1] && (y_i != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[i]   <= pos ? (x_i + dx) : (x_i - dx);
        y_q[i]   <= pos ? (y_i - dy) : (y_i + dy);
        z_q[i]   <= pos ? (z_i + ANG) : (z_i - ANG);
        fl_q[i]  <= fl_i;
        mag_q[i] <= mag_i;
      end
    end
  end

  assign out_valid = v_q[CORDIC_STEPS-1];
  assign z         = z_q[CORDIC_STEPS-1];
  assign out_flags = fl_q[CORDIC_STEPS-1];
  assign out_mag   = mag_q[CORDIC_STEPS-1];

endmodule

// ----- sv/gmd_back.sv -----
// quadrant fixup, rounding to the output scale and threshold gating
module gmd_back import gmd_pkg::*; #(
  parameter int AFB = ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [63:0]        z,
  input  flags_t                    in_flags,
  input  logic [MAG_W-1:0]          in_mag,
  output logic                      out_valid,
  output logic [MAG_W-1:0]          magnitude,
  output logic signed [ANGLE_W-1:0] angle,
  output logic                      above_threshold
);

  localparam int SH = ANG_SCALE - AFB;

  logic             v1;
  word64_t          a1;
  flags_t           fl1;
  logic [MAG_W-1:0] mag1;

  word64_t          a0;
  word64_t          a_c;
  word64_t          rnd;
  word64_t          q;
  logic [ANGLE_W-1:0] qa;
  logic [ANGLE_W-1:0] ang_c;

  // first-quadrant angle with axis cases, then mirror for negative x
  always_comb begin
    if (in_flags.ay_zero) begin
      a0 = '0;
    end else if (in_flags.ax_zero) begin
      a0 = HALF_PI;
    end else if (z[63]) begin
      a0 = '0;
    end else begin
      a0 = word64_t'(z);
    end
    a_c = in_flags.neg_x ? (PI_FIX - a0) : a0;
  end

  // round half up at the output scale, sign from y, zero below threshold or for a zero vector
  assign rnd   = a1 + (word64_t'(1) << (SH - 1));
  assign q     = rnd >> SH;
  assign qa    = q[ANGLE_W-1:0];
  assign ang_c = (fl1.pass && !(fl1.ax_zero && fl1.ay_zero))
                 ? (fl1.neg_y ? (~qa + 1'b1) : qa) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1              <= a_c;
      fl1             <= in_flags;
      mag1            <= in_mag;
      magnitude       <= mag1;
      angle           <= signed'(ang_c);
      above_threshold <= fl1.pass;
    end
  end

endmodule

// ----- dv/gradient_magnitude_direction_tb.sv -----
// testbench for the gradient magnitude and direction block, self-checking against its own predictor
module gradient_magnitude_direction_tb;
  import gmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW          = GRAD_WIDTH_DEF;
  localparam int FRAC        = ANGLE_FRAC_BITS_DEF;
  localparam int DRAIN_SLACK = 90;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SUB_ITEMS   = 117;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
  } grad_pair_t;

  typedef struct packed {
    logic [MAG_W-1:0]          magnitude;
    logic signed [ANGLE_W-1:0] angle;
    logic                      above;
  } pixel_result_t;

  logic clk;
  logic rst;

  gmd_pixel_if  pix_if ();
  gmd_result_if res_if ();
  gmd_cfg_if    cfg_if ();

  gradient_magnitude_direction dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // cordic rotation angles and pi, units of 2^-60 rad
  longint unsigned rot_angle [CORDIC_STEPS];
  longint unsigned pi_q60;

  grad_pair_t      pixel_queue [$];
  pixel_result_t   pending_results [$];
  logic [THR_W-1:0] threshold_shadow;
  int              pixels_queued;
  int              pixels_accepted;
  int              errors;
  int              cycles;
  int              sender_idle_pct;
  int              sink_idle_pct;
  int              ready_hold;
  logic            pixel_taken;

  // atan(1/n) by its alternating series, truncated terms
  function automatic longint unsigned arctan_inverse(input longint unsigned n);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned term;
    int k;
    p   = (64'd1 << ANG_SCALE) / n;
    acc = 0;
    k   = 0;
    while (p != 0) begin
      term = p / longint'(2 * k + 1);
      if ((k & 1) == 0) begin
        acc = acc + term;
      end else begin
        acc = acc - term;
      end
      p = p / n;
      p = p / n;
      k++;
    end
    return acc;
  endfunction

  // expected magnitude, direction and flag of one pixel
  function automatic pixel_result_t predict_pixel(input grad_pair_t px,
                                                  input logic [THR_W-1:0] thr);
    longint gx_i;
    longint gy_i;
    longint ax;
    longint ay;
    longint sum_sq;
    longint root;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint ang;
    longint unsigned dir;
    longint unsigned q;
    logic pass;
    pixel_result_t res;
    gx_i   = px.gx;
    gy_i   = px.gy;
    ax     = (gx_i < 0) ? -gx_i : gx_i;
    ay     = (gy_i < 0) ? -gy_i : gy_i;
    sum_sq = ax * ax + ay * ay;
    // floor square root, then round to nearest
    root = 0;
    for (longint b = 64'd1 << 13; b > 0; b = b >> 1) begin
      if ((root + b) * (root + b) <= sum_sq) root = root + b;
    end
    if (sum_sq >= root * root + root + 1) root = root + 1;
    pass = (sum_sq >= longint'(thr) * longint'(thr));
    ang  = 0;
    if (pass && sum_sq != 0) begin
      // first-quadrant angle
      if (ay == 0) begin
        dir = 0;
      end else if (ax == 0) begin
        dir = pi_q60 / 2;
      end else begin
        x = ax << PRESHIFT;
        y = ay << PRESHIFT;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(rot_angle[i]);
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(rot_angle[i]);
          end
        end
        if (z < 0) z = 0;
        dir = z;
      end
      if (gx_i < 0) dir = pi_q60 - dir;
      q   = (dir + (64'd1 << (ANG_SCALE - FRAC - 1))) >> (ANG_SCALE - FRAC);
      ang = (gy_i < 0) ? -longint'(q) : longint'(q);
    end
    res.magnitude = root[MAG_W-1:0];
    res.angle     = ang[ANGLE_W-1:0];
    res.above     = pass;
    return res;
  endfunction

  // random pixel, weighted toward corners, axes, diagonals and the threshold edge
  function automatic grad_pair_t random_pixel(input logic [THR_W-1:0] thr);
    grad_pair_t p;
    int a;
    int b;
    int tmp;
    int corners [5] = '{-2048, -1, 0, 1, 2047};
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        a = $urandom;
        b = $urandom;
      end
      4: begin
        a = int'($urandom_range(16)) - 8;
        b = int'($urandom_range(16)) - 8;
      end
      5: begin
        a = int'($urandom_range(4095)) - 2048;
        b = 0;
      end
      6: begin
        a = $urandom_range(2047);
        b = a;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end
      7: begin
        a = corners[$urandom_range(4)];
        b = corners[$urandom_range(4)];
      end
      default: begin
        if (thr > 2047) begin
          a = int'(thr) * 181 / 256 + int'($urandom_range(2)) - 1;
          b = a + int'($urandom_range(2)) - 1;
        end else begin
          a = int'(thr) + int'($urandom_range(2)) - 1;
          b = int'($urandom_range(2)) - 1;
        end
        if (a > 2047) a = 2047;
        if (a < 0) a = 0;
        if (b > 2047) b = 2047;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
      end
    endcase
    if ($urandom_range(1)) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    p.gx = a[GW-1:0];
    p.gy = b[GW-1:0];
    return p;
  endfunction

  task automatic queue_pixel(input int gx, input int gy);
    grad_pair_t p;
    p.gx = gx[GW-1:0];
    p.gy = gy[GW-1:0];
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  // sender pause: everything accepted and every result back
  task automatic wait_idle();
    while (pixels_accepted != pixels_queued || pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= THR_W'($urandom);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // pixel driver, fed from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pixel_taken) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        pix_if.valid  <= 1'b1;
        pix_if.grad_x <= pixel_queue[0].gx;
        pix_if.grad_y <= pixel_queue[0].gy;
        pixel_queue.pop_front();
      end else begin
        pix_if.valid  <= 1'b0;
        pix_if.grad_x <= GW'($urandom);
        pix_if.grad_y <= GW'($urandom);
      end
    end
  end

  // result receiver, random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      res_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // monitor: predict on each accepted pixel beat, check each result beat
  always @(posedge clk) begin : monitor
    grad_pair_t    seen;
    pixel_result_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= pix_if.valid && pix_if.ready;
      if (cfg_if.valid && cfg_if.ready) threshold_shadow <= cfg_if.data;
      if (pix_if.valid && pix_if.ready) begin
        seen.gx = pix_if.grad_x;
        seen.gy = pix_if.grad_y;
        pending_results.push_back(predict_pixel(seen, threshold_shadow));
        pixels_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, got mag %0d angle %0d flag %0b",
                   $time, res_if.magnitude, res_if.angle, res_if.above_threshold);
        end else begin
          want = pending_results.pop_front();
          if (res_if.magnitude !== want.magnitude) begin
            errors++;
            $display("%0t: magnitude expected %0d, got %0d",
                     $time, want.magnitude, res_if.magnitude);
          end
          if (res_if.angle !== want.angle) begin
            errors++;
            $display("%0t: angle expected %0d, got %0d", $time, want.angle, res_if.angle);
          end
          if (res_if.above_threshold !== want.above) begin
            errors++;
            $display("%0t: above_threshold expected %0b, got %0b",
                     $time, want.above, res_if.above_threshold);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [THR_W-1:0] thr;
    longint unsigned quarter;
    int corner_px [15][2] = '{
      '{0, 0}, '{2047, 0}, '{-2048, 0}, '{-1, 0}, '{0, 2047},
      '{0, -2048}, '{2047, 2047}, '{-2048, -2048}, '{-2048, 2047}, '{2047, -2048},
      '{1, 1}, '{-1, -1}, '{1, -1}, '{-1, 1}, '{3, 4}
    };
    rst              = 1'b1;
    pix_if.valid     = 1'b0;
    pix_if.grad_x    = '0;
    pix_if.grad_y    = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    threshold_shadow = '0;
    pixels_queued    = 0;
    pixels_accepted  = 0;
    errors           = 0;
    cycles           = 0;
    ready_hold       = 0;
    sender_idle_pct  = 28;
    sink_idle_pct    = 47;

    // angle table
    quarter      = 4 * arctan_inverse(5) - arctan_inverse(239);
    pi_q60       = 4 * quarter;
    rot_angle[0] = quarter;
    for (int i = 1; i < CORDIC_STEPS; i++) rot_angle[i] = arctan_inverse(64'd1 << i);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners, axes and diagonals at the reset threshold
    @(posedge clk);
    foreach (corner_px[i]) queue_pixel(corner_px[i][0], corner_px[i][1]);

    // exact threshold edge around a magnitude of five
    write_threshold(THR_W'(5));
    @(posedge clk);
    queue_pixel(3, 4);
    queue_pixel(-4, -3);
    queue_pixel(3, 3);
    queue_pixel(0, -4);
    queue_pixel(-5, 0);
    queue_pixel(0, 0);

    // largest thresholds against the largest vector
    write_threshold(THR_W'(2896));
    @(posedge clk);
    queue_pixel(-2048, -2048);
    queue_pixel(2047, 2047);
    write_threshold(THR_W'(2897));
    @(posedge clk);
    queue_pixel(-2048, -2048);

    // random part: three idling modes, four thresholds each
    for (int mode = 0; mode < 3; mode++) begin
      for (int sub = 0; sub < 4; sub++) begin
        case (sub)
          0:       thr = '0;
          1:       thr = THR_W'(2897);
          2:       thr = THR_W'($urandom_range(2897));
          default: thr = THR_W'($urandom_range(64));
        endcase
        write_threshold(thr);
        @(posedge clk);
        case (mode)
          0: begin
            sender_idle_pct = 28;
            sink_idle_pct   = 47;
          end
          1: begin
            sender_idle_pct = 47;
            sink_idle_pct   = 28;
          end
          default: begin
            sender_idle_pct = 0;
            sink_idle_pct   = 0;
          end
        endcase
        if (mode == 2 && sub == 2) ready_hold = LONG_HOLD;
        for (int n = 0; n < SUB_ITEMS; n++) pixel_queue.push_back(random_pixel(thr));
        pixels_queued = pixels_queued + SUB_ITEMS;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
